/* rtl/core/absolute_encoder_frame_decode_defines.svh */
// Assertion macros shared by the encoder frame decoder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ABSOLUTE_ENCODER_FRAME_DECODE_DEFINES_SVH
`define ABSOLUTE_ENCODER_FRAME_DECODE_DEFINES_SVH

`ifndef SYNTHESIS
// check that is disabled while reset is asserted
`define AEFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check that holds through reset as well
`define AEFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AEFD_ASSERT(lbl, clk, rstn, prop, msg)
`define AEFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/aefd_pkg.sv */
// Package for the absolute encoder frame decoder: widths, codes and the
// queue word type. No dependencies.
`default_nettype none

package aefd_pkg;

    // stream widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 1;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ANGLE_OFFSET = 1'b0;
    localparam logic REG_FRAME_ID     = 1'b1;

    localparam logic [14:0] ANGLE_OFFSET_RST = 15'd0;
    localparam logic [10:0] FRAME_ID_RST     = 11'h050;

    // frame header codes
    localparam logic [7:0] HDR_SYNC  = 8'h55;
    localparam logic [7:0] HDR_ANGLE = 8'h55;
    localparam logic [7:0] HDR_TEMP  = 8'h56;
    localparam logic [1:0] FIRST_BUS = 2'd0;

    // result kind
    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_TEMP  = 1'b1;

    // angle arithmetic, 32768 units per turn
    localparam logic signed [17:0] DIFF_HALF     = 18'sd16384;
    localparam logic signed [17:0] DIFF_NEG_HALF = -18'sd16384;
    localparam logic signed [17:0] DIFF_TURN     = 18'sd32768;

    // one decoded word between front and back
    typedef struct packed {
        logic        kind;      // KIND_ANGLE or KIND_TEMP
        logic [15:0] value;     // raw angle or temperature
        logic [14:0] rel;       // wrapped angle
        logic        oor;       // wrapped angle still out of range
        logic [15:0] speed;
        logic [15:0] angvel;
    } aefd_item_t;

endpackage

`default_nettype wire

/* rtl/core/aefd_front.sv */
// Front end: accepts received frames, filters by bus, id and header, and
// computes the offset-corrected wrapped angle. Depends on aefd_pkg.
`default_nettype none

module aefd_front (
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [aefd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [aefd_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic [14:0]                   angle_offset,
    input  wire logic [10:0]                   encoder_frame_id,
    input  wire logic                          q_full,
    output      logic                          q_push,
    output      aefd_pkg::aefd_item_t          q_item
);
    import aefd_pkg::*;

    logic [10:0]        frame_id;
    logic [7:0]         b0, b1, b2, b3, b4, b5, b6, b7;
    logic [15:0]        raw;
    logic signed [17:0] diff;
    logic signed [17:0] wrapped;
    logic               match;
    logic               is_angle;
    logic               is_temp;

    // unpack the word
    assign frame_id = s_tdata[10:0];
    assign b0 = s_tdata[18:11];
    assign b1 = s_tdata[26:19];
    assign b2 = s_tdata[34:27];
    assign b3 = s_tdata[42:35];
    assign b4 = s_tdata[50:43];
    assign b5 = s_tdata[58:51];
    assign b6 = s_tdata[66:59];
    assign b7 = s_tdata[74:67];
    assign raw = {b3, b2};

    // classify
    assign match    = (s_tuser == FIRST_BUS) && (frame_id == encoder_frame_id)
                      && (b0 == HDR_SYNC);
    assign is_angle = match && (b1 == HDR_ANGLE);
    assign is_temp  = match && (b1 == HDR_TEMP);

    // offset correction and single wrap into a half turn
    always_comb begin
        diff = $signed({2'b00, raw}) - $signed({3'b000, angle_offset});
        if (diff >= DIFF_HALF) begin
            wrapped = diff - DIFF_TURN;
        end else if (diff <= DIFF_NEG_HALF) begin
            wrapped = diff + DIFF_TURN;
        end else begin
            wrapped = diff;
        end
    end

    // queue word
    always_comb begin
        q_item        = '0;
        q_item.kind   = is_temp ? KIND_TEMP : KIND_ANGLE;
        q_item.value  = raw;
        if (is_angle) begin
            q_item.rel    = wrapped[14:0];
            q_item.oor    = (wrapped >= DIFF_HALF) || (wrapped <= DIFF_NEG_HALF);
            q_item.speed  = {b5, b4};
            q_item.angvel = {b7, b6};
        end
    end

    // frames without a result are dropped here
    assign s_tready = aresetn && !q_full;
    assign q_push   = s_tvalid && s_tready && (is_angle || is_temp);

endmodule

`default_nettype wire

/* rtl/core/aefd_queue.sv */
// Two-entry queue between the front and back ends.
// Depends on aefd_pkg and the assertion macro header.
`default_nettype none
`include "absolute_encoder_frame_decode_defines.svh"

module aefd_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire aefd_pkg::aefd_item_t push_item,
    output      logic                 full,
    input  wire logic                 pop,
    output      logic                 q_valid,
    output      aefd_pkg::aefd_item_t q_item
);
    import aefd_pkg::*;

    aefd_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full    = count_reg[1];
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    `AEFD_ASSERT(a_count_bound, aclk, aresetn, count_reg != 2'd3, "queue count overflow")
    `AEFD_ASSERT(a_no_push_full, aclk, aresetn, !(push && full), "push into full queue")
    `AEFD_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop && !q_valid), "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/core/aefd_back.sv */
// Back end: resolves held angles against the previous angle and drives
// the output register. Depends on aefd_pkg and the assertion macro header.
`default_nettype none
`include "absolute_encoder_frame_decode_defines.svh"

module aefd_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire aefd_pkg::aefd_item_t           q_item,
    output      logic                           q_pop,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [aefd_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic [aefd_pkg::M_TUSER_W-1:0] m_tuser
);
    import aefd_pkg::*;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [14:0] prev_reg, prev_next;
    logic        kind_reg;
    logic [15:0] raw_reg;
    logic [14:0] rel_reg;
    logic        held_reg;
    logic [15:0] speed_reg;
    logic [15:0] angvel_reg;
    logic [15:0] temp_reg;
    logic [14:0] rel_sel;
    logic        is_angle;

    // take a word when the output register is free or draining
    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign is_angle = (q_item.kind == KIND_ANGLE);
    assign rel_sel  = q_item.oor ? prev_reg : q_item.rel;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (q_pop) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        prev_next = (q_pop && is_angle) ? rel_sel : prev_reg;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            prev_reg     <= 15'd0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            prev_reg     <= prev_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= q_item.kind;
            raw_reg    <= is_angle ? q_item.value : 16'd0;
            rel_reg    <= is_angle ? rel_sel : 15'd0;
            held_reg   <= is_angle && q_item.oor;
            speed_reg  <= q_item.speed;
            angvel_reg <= q_item.angvel;
            temp_reg   <= is_angle ? 16'd0 : q_item.value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {temp_reg, angvel_reg, speed_reg, held_reg, rel_reg, raw_reg};

    `AEFD_ASSERT(a_held_repeats, aclk, aresetn,
        (q_pop && is_angle && q_item.oor) |=> (rel_reg == $past(prev_reg)),
        "held angle differs from previous angle")
    `AEFD_ASSERT(a_prev_tracks, aclk, aresetn,
        (q_pop && is_angle) |=> (prev_reg == rel_reg),
        "previous angle not updated from output")
    `AEFD_ASSERT(a_temp_clean, aclk, aresetn,
        (m_tvalid && kind_reg == KIND_TEMP) |-> (raw_reg == 16'd0 && !held_reg),
        "temperature word carries angle data")

endmodule

`default_nettype wire

/* rtl/core/absolute_encoder_frame_decode.sv */
// Absolute encoder frame decoder, top level: configuration registers and
// front/queue/back. Depends on aefd_pkg, aefd_front, aefd_queue, aefd_back.
//
// Usage:
//   s_ channel takes one received CAN frame per word: s_tuser holds the bus,
//   s_tdata the identifier and the eight data bytes. Frames on the first bus
//   with the configured identifier and header 55 55 (angle) or 55 56
//   (temperature) give one word on the m_ channel; all others give none.
//   m_tuser is the frame kind, m_tdata the decoded fields.
//   m_tvalid rises once an accepted frame has passed the queue write and
//   then the output register. Throughput: one frame per cycle while m_tready
//   is high, set by the single front stage feeding a two-entry queue that
//   the output register then drains every cycle.
//   When m_tready is low the output register holds its word; the queue
//   absorbs up to two more results and then s_tready drops.
//   APB port: angle_offset at 0x0, encoder_frame_id at 0x4; pready is
//   always high. Write registers only while the block is idle.
//   Reset (aresetn low, synchronous) empties the queue and output register,
//   clears the previous angle and loads offset 0 and identifier 0x50.
`default_nettype none

module absolute_encoder_frame_decode (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input frames
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // frame_id[10:0], byte_0 .. byte_7 from bit 11 up, zero pad [79:75]
    input  wire logic [aefd_pkg::S_TDATA_W-1:0] s_tdata,
    // can_bus[1:0]
    input  wire logic [aefd_pkg::S_TUSER_W-1:0] s_tuser,
    // results
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // raw_angle[15:0], relative_angle[30:16], angle_held[31],
    // speed[47:32], angular_velocity[63:48], temperature[79:64]
    output      logic [aefd_pkg::M_TDATA_W-1:0] m_tdata,
    // frame_kind[0]
    output      logic [aefd_pkg::M_TUSER_W-1:0] m_tuser,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [aefd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [aefd_pkg::PDATA_W-1:0]   pwdata,
    output      logic [aefd_pkg::PDATA_W-1:0]   prdata,
    output      logic                           pready
);
    import aefd_pkg::*;

    logic [14:0] angle_offset_reg, angle_offset_next;
    logic [10:0] frame_id_reg, frame_id_next;
    logic        cfg_wr;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    aefd_item_t  push_item;
    aefd_item_t  head_item;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        angle_offset_next = angle_offset_reg;
        frame_id_next     = frame_id_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_ANGLE_OFFSET: angle_offset_next = pwdata[14:0];
                REG_FRAME_ID:     frame_id_next     = pwdata[10:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_offset_reg <= ANGLE_OFFSET_RST;
            frame_id_reg     <= FRAME_ID_RST;
        end else begin
            angle_offset_reg <= angle_offset_next;
            frame_id_reg     <= frame_id_next;
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            REG_ANGLE_OFFSET: prdata = {17'd0, angle_offset_reg};
            REG_FRAME_ID:     prdata = {21'd0, frame_id_reg};
            default:          prdata = '0;
        endcase
    end

    aefd_front u_front (
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .angle_offset     (angle_offset_reg),
        .encoder_frame_id (frame_id_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (push_item)
    );

    aefd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (head_item)
    );

    aefd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
